### rtl/core/tca_pkg.sv
// ----------------------------------------------------------------------------
// tca_pkg
// Shared constants for the tiled 3-D cell address translator.
// ----------------------------------------------------------------------------
package tca_pkg;

  // Parameter defaults
  localparam int COORD_BITS_DEF    = 32;
  localparam int TILE_DIM_BITS_DEF = 8;

  // Fixed field widths
  localparam int CHAN_W  = 8;
  localparam int FIELD_W = 32;
  localparam int INDEX_W = 24;
  localparam int REG_W   = 9;
  localparam int CFG_IDX_W = 2;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TILE_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_Y = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TILE_Z = 2'd2;

  localparam logic [REG_W-1:0] TILE_SIZE_RESET = 9'd16;

  // Divider stage grouping: quotient bits resolved per stage
  localparam int DIV_STEPS = 4;

  // Stream widths
  localparam int S_TDATA_W = 104;  // 8 + 3*32
  localparam int M_TDATA_W = 128;  // 8 + 3*32 + 24

endpackage

### rtl/core/tca_div_stage.sv
// ----------------------------------------------------------------------------
// tca_div_stage
// One stage of the pipelined restoring divider, DIV_STEPS quotient bits on
// each of the three axes.
// ----------------------------------------------------------------------------
module tca_div_stage
  import tca_pkg::*;
#(
  parameter int TDB = TILE_DIM_BITS_DEF,
  parameter int PAD = COORD_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CHAN_W-1:0] in_chan,
  input  logic [2:0]        in_neg,
  input  logic [PAD-1:0]    in_num [3],
  input  logic [TDB-1:0]    in_rem [3],
  input  logic [TDB:0]      dsr    [3],
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAN_W-1:0] out_chan,
  output logic [2:0]        out_neg,
  output logic [PAD-1:0]    out_num [3],
  output logic [TDB-1:0]    out_rem [3]
);

  logic           adv;
  logic [PAD-1:0] num_next [3];
  logic [TDB-1:0] rem_next [3];

  assign adv      = !out_valid || out_ready;
  assign in_ready = adv;

  // Shift-subtract steps, one quotient bit each
  always_comb begin
    logic [TDB:0]   trial;
    logic [PAD-1:0] n;
    logic [TDB-1:0] r;
    for (int a = 0; a < 3; a++) begin
      n = in_num[a];
      r = in_rem[a];
      for (int s = 0; s < DIV_STEPS; s++) begin
        trial = {r, n[PAD-1]};
        n     = {n[PAD-2:0], 1'b0};
        if (trial >= dsr[a]) begin
          trial = trial - dsr[a];
          n[0]  = 1'b1;
        end
        r = trial[TDB-1:0];
      end
      num_next[a] = n;
      rem_next[a] = r;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_chan <= in_chan;
      out_neg  <= in_neg;
      out_num  <= num_next;
      out_rem  <= rem_next;
    end
  end

endmodule

### rtl/core/tca_index.sv
// ----------------------------------------------------------------------------
// tca_index
// Floor correction for negative coordinates, then the two-step multiply-add
// that forms the in-tile cell index, with the output register.
// ----------------------------------------------------------------------------
module tca_index
  import tca_pkg::*;
#(
  parameter int CB  = COORD_BITS_DEF,
  parameter int TDB = TILE_DIM_BITS_DEF,
  parameter int PAD = COORD_BITS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [CHAN_W-1:0]  in_chan,
  input  logic [2:0]         in_neg,
  input  logic [PAD-1:0]     in_num [3],
  input  logic [TDB-1:0]     in_rem [3],
  input  logic [TDB:0]       dsr    [3],
  output logic               out_valid,
  input  logic               out_ready,
  output logic [CHAN_W-1:0]  out_chan,
  output logic [FIELD_W-1:0] out_tile [3],
  output logic [INDEX_W-1:0] out_index
);

  localparam int TW = 2 * TDB;
  localparam int IW = 3 * TDB;

  logic adv_a, adv_b, adv_c;
  logic vld_a, vld_b;

  // stage A: tile and offset
  logic [CHAN_W-1:0]  chan_a;
  logic [FIELD_W-1:0] tile_a [3];
  logic [TDB-1:0]     off_a  [3];
  // stage B: oz*sy + oy
  logic [CHAN_W-1:0]  chan_b;
  logic [FIELD_W-1:0] tile_b [3];
  logic [TDB-1:0]     ox_b;
  logic [TW-1:0]      part_b;
  logic [TW:0]        part_next;
  logic [IW:0]        full_next;

  assign adv_c    = !out_valid || out_ready;
  assign adv_b    = !vld_b || adv_c;
  assign adv_a    = !vld_a || adv_b;
  assign in_ready = adv_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_a     <= 1'b0;
      vld_b     <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (adv_a) vld_a <= in_valid;
      if (adv_b) vld_b <= vld_a;
      if (adv_c) out_valid <= vld_b;
    end
  end

  // Negative coordinates were divided as ~c: floor is ~q, offset d-1-r
  always_ff @(posedge clk) begin
    logic [CB-1:0] q;
    if (adv_a) begin
      chan_a <= in_chan;
      for (int a = 0; a < 3; a++) begin
        q = in_neg[a] ? ~in_num[a][CB-1:0] : in_num[a][CB-1:0];
        tile_a[a] <= FIELD_W'(signed'(q));
        off_a[a]  <= in_neg[a] ? TDB'(dsr[a] - (TDB+1)'(1) - (TDB+1)'(in_rem[a]))
                               : in_rem[a];
      end
    end
  end

  assign part_next = (TW+1)'(off_a[2]) * (TW+1)'(dsr[1]) + (TW+1)'(off_a[1]);
  assign full_next = (IW+1)'(part_b) * (IW+1)'(dsr[0]) + (IW+1)'(ox_b);

  always_ff @(posedge clk) begin
    if (adv_b) begin
      chan_b <= chan_a;
      tile_b <= tile_a;
      ox_b   <= off_a[0];
      part_b <= part_next[TW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv_c) begin
      out_chan  <= chan_b;
      out_tile  <= tile_b;
      out_index <= INDEX_W'(full_next[IW-1:0]);
    end
  end

endmodule

### rtl/core/tiled_3d_cell_address.sv
// Path: input register, the divider stages, then tca_index stages A, B and the output register.
// Throughput: one coordinate triple per cycle; each divider stage resolves
// four quotient bits per axis, and every stage stalls only when full and blocked.
// Reset: synchronous, clears all valid bits and sets every tile size to 16.
// Tile sizes are read live; write them only while the pipeline is empty.
// ----------------------------------------------------------------------------
// tiled_3d_cell_address
// Splits signed 3-D cell coordinates into tile coordinates (floor quotient)
// and a linear in-tile cell index.
// ----------------------------------------------------------------------------
module tiled_3d_cell_address
  import tca_pkg::*;
#(
  parameter int COORD_BITS    = COORD_BITS_DEF,
  parameter int TILE_DIM_BITS = TILE_DIM_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_write,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [REG_W-1:0]     cfg_data,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // channel_in[7:0], coord_x[39:8], coord_y[71:40], coord_z[103:72]
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // channel_out[7:0], tile_x[39:8], tile_y[71:40], tile_z[103:72],
  // cell_index[127:104]
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  localparam int TDB   = TILE_DIM_BITS;
  localparam int CB    = COORD_BITS;
  localparam int NDIV  = (CB + DIV_STEPS - 1) / DIV_STEPS;
  localparam int PAD   = NDIV * DIV_STEPS;
  localparam int SW    = 11;
  localparam logic [SW-1:0] LIM = SW'(1) << TDB;

  // Configuration registers
  logic [REG_W-1:0] size_reg [3];
  logic [TDB:0]     dsr [3];

  always_ff @(posedge clk) begin
    if (rst) begin
      size_reg[0] <= TILE_SIZE_RESET;
      size_reg[1] <= TILE_SIZE_RESET;
      size_reg[2] <= TILE_SIZE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TILE_X: size_reg[0] <= cfg_data;
        REG_TILE_Y: size_reg[1] <= cfg_data;
        REG_TILE_Z: size_reg[2] <= cfg_data;
        default: ;
      endcase
    end
  end

  // Effective divisor: zero acts as one, clamp to 2^TDB
  always_comb begin
    logic [SW-1:0] s;
    for (int a = 0; a < 3; a++) begin
      s = SW'(size_reg[a]);
      if (s == '0) s = SW'(1);
      if (s > LIM) s = LIM;
      dsr[a] = s[TDB:0];
    end
  end

  // Input stage: sign and divider operand (~c for negative coordinates) for each axis
  logic              v0, rdy0;
  logic [CHAN_W-1:0] chan0;
  logic [2:0]        neg0;
  logic [PAD-1:0]    num0 [3];
  logic [TDB-1:0]    rem0 [3];

  assign s_axis_tready = !v0 || rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
    end else if (s_axis_tready) begin
      v0 <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    logic [CB-1:0] c;
    if (s_axis_tready) begin
      chan0 <= s_axis_tdata[CHAN_W-1:0];
      for (int a = 0; a < 3; a++) begin
        c = s_axis_tdata[CHAN_W + a*FIELD_W +: CB];
        neg0[a] <= c[CB-1];
        num0[a] <= PAD'(c[CB-1] ? ~c : c);
        rem0[a] <= '0;
      end
    end
  end

  // Divider pipeline
  logic              dv   [NDIV+1];
  logic              drdy [NDIV+1];
  logic [CHAN_W-1:0] dchan[NDIV+1];
  logic [2:0]        dneg [NDIV+1];
  logic [PAD-1:0]    dnum [NDIV+1][3];
  logic [TDB-1:0]    drem [NDIV+1][3];

  assign dv[0]    = v0;
  assign rdy0     = drdy[0];
  assign dchan[0] = chan0;
  assign dneg[0]  = neg0;
  assign dnum[0]  = num0;
  assign drem[0]  = rem0;

  for (genvar i = 0; i < NDIV; i++) begin : g_div
    tca_div_stage #(.TDB(TDB), .PAD(PAD)) u_stage (
      .clk      (clk),
      .rst      (rst),
      .in_valid (dv[i]),
      .in_ready (drdy[i]),
      .in_chan  (dchan[i]),
      .in_neg   (dneg[i]),
      .in_num   (dnum[i]),
      .in_rem   (drem[i]),
      .dsr      (dsr),
      .out_valid(dv[i+1]),
      .out_ready(drdy[i+1]),
      .out_chan (dchan[i+1]),
      .out_neg  (dneg[i+1]),
      .out_num  (dnum[i+1]),
      .out_rem  (drem[i+1])
    );
  end

  // Offset correction and index multiply-add
  logic [CHAN_W-1:0]  chan_o;
  logic [FIELD_W-1:0] tile_o [3];
  logic [INDEX_W-1:0] index_o;

  tca_index #(.CB(CB), .TDB(TDB), .PAD(PAD)) u_index (
    .clk      (clk),
    .rst      (rst),
    .in_valid (dv[NDIV]),
    .in_ready (drdy[NDIV]),
    .in_chan  (dchan[NDIV]),
    .in_neg   (dneg[NDIV]),
    .in_num   (dnum[NDIV]),
    .in_rem   (drem[NDIV]),
    .dsr      (dsr),
    .out_valid(m_axis_tvalid),
    .out_ready(m_axis_tready),
    .out_chan (chan_o),
    .out_tile (tile_o),
    .out_index(index_o)
  );

  assign m_axis_tdata = {index_o, tile_o[2], tile_o[1], tile_o[0], chan_o};

  // Checks
  a_reset_clears: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output valid after reset");
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");
  a_divisor_nonzero: assert property (@(posedge clk) disable iff (rst)
    dsr[0] != '0 && dsr[1] != '0 && dsr[2] != '0)
    else $error("zero effective tile size");

endmodule

### test/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Testbench for tiled_3d_cell_address. Signed coordinate triples are streamed
// in under several tile-size settings. A scoreboard predicts the tile
// coordinates and the in-tile index by floor division and compares every
// output transaction in order. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module tb
  import tca_pkg::*;
();

  // register index that maps to no register
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int STALL_LIMIT = 5000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_CYCLES = 30;
  localparam int RANDOM_ITEMS = 850;

  // Expected-result tracker for the address translation
  class addr_scoreboard;
    logic [REG_W-1:0] size_x, size_y, size_z;
    logic [M_TDATA_W-1:0] expected_q[$];
    int errors;

    function new();
      size_x = TILE_SIZE_RESET;
      size_y = TILE_SIZE_RESET;
      size_z = TILE_SIZE_RESET;
      errors = 0;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
      case (idx)
        REG_TILE_X: size_x = val;
        REG_TILE_Y: size_y = val;
        REG_TILE_Z: size_z = val;
        default: ;
      endcase
    endfunction

    // zero acts as one, above 256 clamps to 256
    function longint clamp_size(logic [REG_W-1:0] r);
      longint s;
      s = longint'(r);
      if (s < 1) s = 1;
      if (s > 256) s = 256;
      return s;
    endfunction

    function void split_axis(logic [FIELD_W-1:0] raw, longint s,
                             output longint quo, output longint off);
      longint c;
      c = longint'($signed(raw));
      quo = c / s;
      off = c % s;
      if (off < 0) begin
        off += s;
        quo -= 1;
      end
    endfunction

    function void note_input(logic [S_TDATA_W-1:0] d);
      longint sx, sy, sz, qx, qy, qz, ox, oy, oz, idx;
      logic [M_TDATA_W-1:0] r;
      sx = clamp_size(size_x);
      sy = clamp_size(size_y);
      sz = clamp_size(size_z);
      split_axis(d[39:8], sx, qx, ox);
      split_axis(d[71:40], sy, qy, oy);
      split_axis(d[103:72], sz, qz, oz);
      idx = oz * sy * sx + oy * sx + ox;
      r[7:0] = d[7:0];
      r[39:8] = qx[31:0];
      r[71:40] = qy[31:0];
      r[103:72] = qz[31:0];
      r[127:104] = idx[23:0];
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [M_TDATA_W-1:0] d);
      logic [M_TDATA_W-1:0] e;
      if (expected_q.size() == 0) begin
        $error("unexpected output transaction %h", d);
        errors++;
        return;
      end
      e = expected_q.pop_front();
      if (d[7:0] !== e[7:0]) begin
        $error("channel_out exp %0d got %0d", e[7:0], d[7:0]);
        errors++;
      end
      if (d[39:8] !== e[39:8]) begin
        $error("tile_x exp %0d got %0d", $signed(e[39:8]), $signed(d[39:8]));
        errors++;
      end
      if (d[71:40] !== e[71:40]) begin
        $error("tile_y exp %0d got %0d", $signed(e[71:40]), $signed(d[71:40]));
        errors++;
      end
      if (d[103:72] !== e[103:72]) begin
        $error("tile_z exp %0d got %0d", $signed(e[103:72]), $signed(d[103:72]));
        errors++;
      end
      if (d[127:104] !== e[127:104]) begin
        $error("cell_index exp %0d got %0d", e[127:104], d[127:104]);
        errors++;
      end
    endfunction
  endclass

  logic clk, rst;
  logic cfg_write;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [REG_W-1:0] cfg_data;
  logic s_axis_tvalid, s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [M_TDATA_W-1:0] m_axis_tdata;

  addr_scoreboard sb = new();
  int send_idle_pct = 37;
  int recv_idle_pct = 46;
  int sent_count = 0;
  bit hold_done = 0;
  int quiet_cycles = 0;

  tiled_3d_cell_address u_top (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Monitors: note inputs, check outputs, watch for a hang
  always @(posedge clk) begin
    if (!rst) begin
      if (s_axis_tvalid && s_axis_tready) sb.note_input(s_axis_tdata);
      if (m_axis_tvalid && m_axis_tready) sb.check_result(m_axis_tdata);
      if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > STALL_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver: random stalls plus one long hold-off once traffic is steady
  initial begin
    m_axis_tready = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (!hold_done && sent_count > 2 * RANDOM_ITEMS / 3) begin
        hold_done = 1;
        m_axis_tready <= 0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      @(negedge clk);
    end
  end

  // Send one transaction; called at a falling edge
  task automatic send_coord(logic [7:0] ch, logic [31:0] x, logic [31:0] y,
                            logic [31:0] z);
    s_axis_tvalid <= 1;
    s_axis_tdata <= {z, y, x, ch};
    do @(posedge clk); while (!s_axis_tready);
    @(negedge clk);
    sent_count++;
    if ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(4, 1)) @(negedge clk);
    end
  endtask

  // Stop sending and wait for the pipeline to empty
  task automatic drain;
    s_axis_tvalid <= 0;
    while (sb.expected_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [REG_W-1:0] val);
    cfg_write <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 0;
    sb.write_reg(idx, val);
  endtask

  task automatic set_sizes(logic [REG_W-1:0] x, logic [REG_W-1:0] y,
                           logic [REG_W-1:0] z);
    drain();
    write_reg(REG_TILE_X, x);
    write_reg(REG_TILE_Y, y);
    write_reg(REG_TILE_Z, z);
    write_reg(REG_UNUSED, REG_W'($urandom_range(511)));
  endtask

  // Mostly small coordinates around zero and near the signed extremes, some full range
  function automatic logic [31:0] rand_coord();
    case ($urandom_range(3))
      0: return $urandom;
      1: return 32'($signed($urandom_range(2048)) - 1024);
      2: return $urandom_range(1) ? 32'h8000_0000 + $urandom_range(600)
                                  : 32'h7fff_ffff - $urandom_range(600);
      default: return 32'($signed($urandom_range(1)) * -1) ^ $urandom_range(300);
    endcase
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) begin
      if (sent_count > RANDOM_ITEMS / 3) begin
        send_idle_pct = 46;
        recv_idle_pct = 37;
      end
      if (sent_count > 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send_coord(8'($urandom), rand_coord(), rand_coord(), rand_coord());
    end
  endtask

  initial begin
    rst = 1;
    cfg_write = 0;
    cfg_index = REG_TILE_X;
    cfg_data = '0;
    s_axis_tvalid = 0;
    s_axis_tdata = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 0;

    // Directed: reset sizes, coordinate extremes and tile boundaries
    send_coord(8'd0, 32'd0, 32'd0, 32'd0);
    send_coord(8'd255, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    send_coord(8'h5a, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff);
    send_coord(8'ha5, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
    send_coord(8'd1, 32'd15, 32'd16, 32'd17);
    send_coord(8'd2, -32'sd16, -32'sd17, -32'sd15);
    set_sizes(9'd1, 9'd1, 9'd1);
    send_coord(8'd3, 32'h8000_0000, 32'h7fff_ffff, -32'sd1);
    set_sizes(9'd256, 9'd256, 9'd256);
    send_coord(8'd4, 32'd255, 32'd255, 32'd255);
    send_coord(8'd5, -32'sd1, -32'sd1, -32'sd1);
    send_coord(8'd6, 32'h8000_0000, 32'h7fff_ffff, -32'sd256);
    // zero acts as one, oversized sizes clamp
    set_sizes(9'd0, 9'd511, 9'd257);
    send_coord(8'd7, -32'sd3, -32'sd1, -32'sd257);
    send_coord(8'd8, 32'h7fff_ffff, 32'd300, 32'd511);

    // Random traffic across several settings
    set_sizes(9'd16, 9'd16, 9'd16);
    send_random(RANDOM_ITEMS / 8);
    set_sizes(9'd3, 9'd7, 9'd5);
    send_random(RANDOM_ITEMS / 8);
    set_sizes(9'd256, 9'd1, 9'd256);
    send_random(RANDOM_ITEMS / 8);
    set_sizes(9'd0, 9'd300, 9'd2);
    send_random(RANDOM_ITEMS / 8);
    for (int k = 0; k < 4; k++) begin
      set_sizes(REG_W'($urandom_range(511)), REG_W'($urandom_range(511)),
                REG_W'($urandom_range(511)));
      send_random(RANDOM_ITEMS / 8);
    end

    drain();
    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end
endmodule
